/* rtl/vel_pkg.sv */
// Package for the visible escape line wrapper.
// Types and constants shared by all rtl/ modules; escape-letter lookup for vel_front.
package vel_pkg;

  localparam int unsigned WidthW = 12;
  localparam int unsigned CountW = 13;
  localparam logic [WidthW-1:0] WidthReset = 12'd60;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned IdxW   = 3;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTilde     = 8'h7E;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_LETTER = 2'd1,
    KIND_OCTAL  = 2'd2,
    KIND_END    = 2'd3
  } vel_kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } vel_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } vel_out_t;

  typedef struct packed {
    logic       wrap;
    vel_kind_e  kind;
    logic [7:0] value;
  } vel_job_t;

  function automatic logic [7:0] letter_for(input logic [7:0] b);
    logic [7:0] l;
    case (b)
      8'h5C:   l = 8'h5C;
      8'h07:   l = 8'h61;
      8'h08:   l = 8'h62;
      8'h0C:   l = 8'h66;
      8'h0A:   l = 8'h6E;
      8'h0D:   l = 8'h72;
      8'h09:   l = 8'h74;
      8'h0B:   l = 8'h76;
      default: l = 8'h00;
    endcase
    return l;
  endfunction

endpackage

/* rtl/vel_front.sv */
// Front end: width register, column count, wrap check and byte classification.
// Depends on vel_pkg.
module vel_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vel_pkg::WidthW-1:0]    cfg_wdata_i,
  input  logic                          accept_i,
  input  vel_pkg::vel_in_t              in_item_i,
  output vel_pkg::vel_job_t             job_o
);

  logic [vel_pkg::WidthW-1:0] width_q;
  logic [vel_pkg::CountW-1:0] count_q, count_d, base;
  logic [2:0]                 inc;
  logic [7:0]                 letter;
  logic                       printable;

  always_comb begin
    letter    = vel_pkg::letter_for(in_item_i.data_byte);
    printable = (in_item_i.data_byte >= vel_pkg::ChSpace) &&
                (in_item_i.data_byte <= vel_pkg::ChTilde) &&
                (in_item_i.data_byte != vel_pkg::ChBackslash);
    job_o.wrap  = !in_item_i.action && (count_q >= {1'b0, width_q});
    job_o.value = in_item_i.data_byte;
    if (in_item_i.action) begin
      job_o.kind = vel_pkg::KIND_END;
      inc        = 3'd0;
    end else if (printable) begin
      job_o.kind = vel_pkg::KIND_CHAR;
      inc        = 3'd1;
    end else if (letter != 8'h00) begin
      job_o.kind  = vel_pkg::KIND_LETTER;
      job_o.value = letter;
      inc         = 3'd2;
    end else begin
      job_o.kind = vel_pkg::KIND_OCTAL;
      inc        = 3'd4;
    end
    base    = job_o.wrap ? '0 : count_q;
    count_d = in_item_i.action ? '0 : base + vel_pkg::CountW'(inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= vel_pkg::WidthReset;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        count_q <= count_d;
      end
    end
  end

endmodule

/* rtl/vel_queue.sv */
// Short job queue between front and back.
// Depends on vel_pkg.
module vel_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vel_pkg::vel_job_t job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output vel_pkg::vel_job_t head_o
);

  vel_pkg::vel_job_t               mem_q [vel_pkg::QDepth];
  logic [vel_pkg::QAddrW-1:0]      wr_q, rd_q;
  logic [vel_pkg::QCntW-1:0]       cnt_q;

  assign full_o  = (cnt_q == vel_pkg::QCntW'(vel_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/vel_back.sv */
// Back end: steps through the characters of the head job, one per transfer.
// Depends on vel_pkg.
module vel_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vel_pkg::vel_job_t job_i,
  input  logic              empty_i,
  input  logic              pop_i,
  output logic              retire_o,
  output vel_pkg::vel_out_t out_item_o
);

  logic [vel_pkg::IdxW-1:0] idx_q, len, j;
  logic                     take, last;

  always_comb begin
    case (job_i.kind)
      vel_pkg::KIND_CHAR:   len = 3'd1;
      vel_pkg::KIND_LETTER: len = 3'd2;
      vel_pkg::KIND_OCTAL:  len = 3'd4;
      vel_pkg::KIND_END:    len = 3'd2;
      default:              len = 3'd1;
    endcase
    if (job_i.wrap) begin
      len = len + 3'd2;
      j   = idx_q - 3'd2;
    end else begin
      j = idx_q;
    end
    last = (idx_q == len - 3'd1);

    if (job_i.wrap && (idx_q < 3'd2)) begin
      out_item_o.out_byte = (idx_q == 3'd0) ? vel_pkg::ChBackslash : vel_pkg::ChNewline;
    end else begin
      case (job_i.kind)
        vel_pkg::KIND_CHAR: begin
          out_item_o.out_byte = job_i.value;
        end
        vel_pkg::KIND_LETTER: begin
          out_item_o.out_byte = (j == 3'd0) ? vel_pkg::ChBackslash : job_i.value;
        end
        vel_pkg::KIND_OCTAL: begin
          case (j)
            3'd0:    out_item_o.out_byte = vel_pkg::ChBackslash;
            3'd1:    out_item_o.out_byte = vel_pkg::ChZero + {6'd0, job_i.value[7:6]};
            3'd2:    out_item_o.out_byte = vel_pkg::ChZero + {5'd0, job_i.value[5:3]};
            default: out_item_o.out_byte = vel_pkg::ChZero + {5'd0, job_i.value[2:0]};
          endcase
        end
        vel_pkg::KIND_END: begin
          out_item_o.out_byte = (j == 3'd0) ? vel_pkg::ChDollar : vel_pkg::ChNewline;
        end
        default: begin
          out_item_o.out_byte = job_i.value;
        end
      endcase
    end
    out_item_o.last_of_run = last;

    take     = pop_i && !empty_i;
    retire_o = take && last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= last ? '0 : idx_q + 3'd1;
    end
  end

endmodule

/* rtl/visible_escape_line_wrapper.sv */
// Top level of the visible escape line wrapper: front, job queue, back.
// Depends on vel_pkg, vel_front, vel_queue, vel_back.
//
//  channel  | handshake       | payload
//  ---------+-----------------+-------------------------------
//  input    | push / full     | in_item_i  (action, data_byte)
//  result   | empty / pop     | out_item_o (out_byte, last_of_run)
//  config   | cfg_we_i        | cfg_wdata_i (line_width)
//
// One result character per cycle while pop is high and the queue is not empty;
// an item has 1 to 6 result characters, so plain bytes stream at one per cycle.
// Input is taken while the 4-entry job queue has room, so the front keeps
// accepting while the back waits on pop. Reset clears the column count,
// the queue and the character index; line_width resets to 60.
module visible_escape_line_wrapper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  vel_pkg::vel_in_t           in_item_i,
  output logic                       empty,
  input  logic                       pop,
  output vel_pkg::vel_out_t          out_item_o,
  input  logic                       cfg_we_i,
  input  logic [vel_pkg::WidthW-1:0] cfg_wdata_i
);

  vel_pkg::vel_job_t job, head;
  logic              accept, retire;

  assign accept = push && !full;

  vel_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .job_o       (job)
  );

  vel_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .job_i   (job),
    .pop_i   (retire),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  vel_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head),
    .empty_i    (empty),
    .pop_i      (pop),
    .retire_o   (retire),
    .out_item_o (out_item_o)
  );

endmodule

/* tb/sv/visible_escape_line_wrapper_tb.sv */
// Self-checking testbench for visible_escape_line_wrapper.
// Drives bytes and end-of-line items, predicts the escaped and wrapped text,
// and checks every result transfer. Depends on vel_pkg and the rtl/ modules.
`timescale 1ns / 100ps

module visible_escape_line_wrapper_tb;

  localparam logic ActEncode = 1'b0;
  localparam logic ActEnd    = 1'b1;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         push        = 1'b0;
  logic                         full;
  vel_pkg::vel_in_t             in_item_i   = '0;
  logic                         empty;
  logic                         pop         = 1'b0;
  vel_pkg::vel_out_t            out_item_o;
  logic                         cfg_we_i    = 1'b0;
  logic [vel_pkg::WidthW-1:0]   cfg_wdata_i = '0;

  // predictor state
  logic [vel_pkg::WidthW-1:0]   width_q  = vel_pkg::WidthReset;
  logic [vel_pkg::CountW-1:0]   column_q = '0;
  vel_pkg::vel_out_t            expected_chars[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int n_items       = 0;
  int n_chars       = 0;
  int n_wraps       = 0;
  int n_errors      = 0;

  visible_escape_line_wrapper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic void encode_item(input vel_pkg::vel_in_t it);
    logic [7:0]        seq[$];
    logic [7:0]        letter;
    vel_pkg::vel_out_t ch;
    logic [7:0]        b;
    b = it.data_byte;
    if (it.action == ActEnd) begin
      seq.push_back(vel_pkg::ChDollar);
      seq.push_back(vel_pkg::ChNewline);
      column_q = '0;
    end else begin
      if (column_q >= {1'b0, width_q}) begin
        seq.push_back(vel_pkg::ChBackslash);
        seq.push_back(vel_pkg::ChNewline);
        column_q = '0;
        n_wraps++;
      end
      case (b)
        8'h5C:   letter = "\\";
        8'h07:   letter = "a";
        8'h08:   letter = "b";
        8'h0C:   letter = "f";
        8'h0A:   letter = "n";
        8'h0D:   letter = "r";
        8'h09:   letter = "t";
        8'h0B:   letter = "v";
        default: letter = 8'h00;
      endcase
      if (b >= vel_pkg::ChSpace && b <= vel_pkg::ChTilde && b != vel_pkg::ChBackslash) begin
        seq.push_back(b);
        column_q = column_q + vel_pkg::CountW'(1);
      end else if (letter != 8'h00) begin
        seq.push_back(vel_pkg::ChBackslash);
        seq.push_back(letter);
        column_q = column_q + vel_pkg::CountW'(2);
      end else begin
        seq.push_back(vel_pkg::ChBackslash);
        seq.push_back(vel_pkg::ChZero + {6'd0, b[7:6]});
        seq.push_back(vel_pkg::ChZero + {5'd0, b[5:3]});
        seq.push_back(vel_pkg::ChZero + {5'd0, b[2:0]});
        column_q = column_q + vel_pkg::CountW'(4);
      end
    end
    foreach (seq[i]) begin
      ch.out_byte    = seq[i];
      ch.last_of_run = (i == seq.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // result side: check on each transfer, then pick next pop
  always @(posedge clk_i) begin : result_check
    vel_pkg::vel_out_t want;
    if (rst_ni && pop && !empty) begin
      n_chars++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h/%0b", $time,
                 out_item_o.out_byte, out_item_o.last_of_run);
        n_errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_item_o.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time,
                   want.out_byte, out_item_o.out_byte);
          n_errors++;
        end
        if (out_item_o.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time,
                   want.last_of_run, out_item_o.last_of_run);
          n_errors++;
        end
      end
    end
    pop <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic act, input logic [7:0] data);
    vel_pkg::vel_in_t it;
    it.action    = act;
    it.data_byte = data;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    encode_item(it);
    n_items++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [vel_pkg::WidthW-1:0] w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_q = w;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 80; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 80; end
      default: begin send_idle_pct = 28; stall_pct = 28; end
    endcase
  endtask

  // every character class at the reset width
  task automatic test_char_classes();
    set_idling(0);
    send_item(ActEncode, 8'h20);
    send_item(ActEncode, 8'h7E);
    send_item(ActEncode, "A");
    send_item(ActEncode, 8'h5C);
    send_item(ActEncode, 8'h07);
    send_item(ActEncode, 8'h08);
    send_item(ActEncode, 8'h09);
    send_item(ActEncode, 8'h0A);
    send_item(ActEncode, 8'h0B);
    send_item(ActEncode, 8'h0C);
    send_item(ActEncode, 8'h0D);
    send_item(ActEncode, 8'h00);
    send_item(ActEncode, 8'h1F);
    send_item(ActEncode, 8'h7F);
    send_item(ActEncode, 8'h80);
    send_item(ActEncode, 8'hFF);
    send_item(ActEnd, 8'hFF);
    drain();
  endtask

  // width 0 wraps before every data byte, never before an end
  task automatic test_zero_width();
    write_width(12'd0);
    send_item(ActEncode, "x");
    send_item(ActEncode, 8'h00);
    send_item(ActEnd, 8'h5C);
    send_item(ActEncode, "y");
    drain();
  endtask

  // line runs past the width, then the width drops below the column
  task automatic test_overrun_and_lowered();
    write_width(12'd5);
    send_item(ActEncode, 8'h01);
    send_item(ActEncode, 8'h02);
    send_item(ActEncode, 8'h03);
    drain();
    write_width(12'd2);
    send_item(ActEncode, "a");
    drain();
  endtask

  task automatic test_random_stream();
    logic [vel_pkg::WidthW-1:0] w;
    int                         r;
    logic [7:0]                 b;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       w = 12'd4095;
        1:       w = 12'd0;
        2:       w = 12'd1;
        3:       w = 12'd3;
        4:       w = 12'd60;
        5:       w = 12'd7;
        default: w = vel_pkg::WidthW'($urandom_range(80, 2));
      endcase
      write_width(w);
      set_idling(ph % 4);
      for (int i = 0; i < 24; i++) begin
        r = $urandom_range(99);
        if (r < 40) begin
          b = 8'($urandom_range(8'h7E, 8'h20));
        end else if (r < 55) begin
          case ($urandom_range(7))
            0:       b = 8'h5C;
            1:       b = 8'h07;
            2:       b = 8'h08;
            3:       b = 8'h09;
            4:       b = 8'h0A;
            5:       b = 8'h0B;
            6:       b = 8'h0C;
            default: b = 8'h0D;
          endcase
        end else begin
          b = 8'($urandom_range(255));
        end
        send_item((r >= 92) ? ActEnd : ActEncode, b);
      end
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_char_classes();
    test_zero_width();
    test_overrun_and_lowered();
    test_random_stream();
    if (expected_chars.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_chars.size());
      n_errors++;
    end
    $display("Ran %0d input transfers and %0d result transfers, %0d line wraps,",
             n_items, n_chars, n_wraps);
    $display("over widths from 0 to 4095 with sender gaps and receiver stalls.");
    if (n_errors == 0) begin
      $display("visible_escape_line_wrapper verification clean");
    end else begin
      $display("visible_escape_line_wrapper verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("visible_escape_line_wrapper verification failed");
    $finish;
  end

endmodule

/* visible_escape_line_wrapper.f */
rtl/vel_pkg.sv
rtl/vel_front.sv
rtl/vel_queue.sv
rtl/vel_back.sv
rtl/visible_escape_line_wrapper.sv
tb/sv/visible_escape_line_wrapper_tb.sv
